// ===== sv/eight_voice_pcm_sample_player_core_assert.svh =====
// ----------------------------------------------------------------------------
// eight_voice_pcm_sample_player_core_assert
// assertion macros shared by the pcm player rtl, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef EIGHT_VOICE_PCM_SAMPLE_PLAYER_CORE_ASSERT_SVH
`define EIGHT_VOICE_PCM_SAMPLE_PLAYER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define PCMP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PCMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCMP_ASSERT_SAME(label, ante, cons, msg)
`define PCMP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/pcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmp_pkg
// shared types and register map of the eight voice pcm sample player
// ----------------------------------------------------------------------------
package pcmp_pkg;

  // voice slots carried by the ports
  localparam int unsigned MAX_VOICES  = 8;
  localparam int unsigned NUM_VOICES  = 8;
  localparam int unsigned VOICE_W     = 3;
  localparam int unsigned REG_BYTES   = 256;
  localparam int unsigned REG_ADDR_W  = 8;
  localparam int unsigned REG_SEL_W   = 5;

  localparam int unsigned PTR_W       = 24;
  localparam int unsigned POS_W       = 26;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned FETCH_W     = 21;
  localparam int unsigned PROD_W      = 16;
  localparam int unsigned MIX_W       = 19;
  localparam int unsigned OUT_W       = 15;

  localparam int unsigned S_TDATA_W   = 80;
  localparam int unsigned S_TUSER_W   = 2;
  localparam int unsigned M_TDATA_W   = 208;

  // per voice register offsets
  localparam logic [REG_SEL_W-1:0] REG_START_LO  = 5'h00;
  localparam logic [REG_SEL_W-1:0] REG_START_MID = 5'h01;
  localparam logic [REG_SEL_W-1:0] REG_START_HI  = 5'h02;
  localparam logic [REG_SEL_W-1:0] REG_LSTART_LO  = 5'h04;
  localparam logic [REG_SEL_W-1:0] REG_LSTART_MID = 5'h05;
  localparam logic [REG_SEL_W-1:0] REG_LSTART_HI  = 5'h06;
  localparam logic [REG_SEL_W-1:0] REG_LEND_LO  = 5'h08;
  localparam logic [REG_SEL_W-1:0] REG_LEND_MID = 5'h09;
  localparam logic [REG_SEL_W-1:0] REG_LEND_HI  = 5'h0a;
  localparam logic [REG_SEL_W-1:0] REG_END_LO  = 5'h0c;
  localparam logic [REG_SEL_W-1:0] REG_END_MID = 5'h0d;
  localparam logic [REG_SEL_W-1:0] REG_END_HI  = 5'h0e;
  localparam logic [REG_SEL_W-1:0] REG_STEP_LO = 5'h10;
  localparam logic [REG_SEL_W-1:0] REG_STEP_HI = 5'h11;
  localparam logic [REG_SEL_W-1:0] REG_VOL_L   = 5'h14;
  localparam logic [REG_SEL_W-1:0] REG_VOL_R   = 5'h15;
  localparam logic [REG_SEL_W-1:0] REG_FLAGS   = 5'h16;

  localparam logic [7:0] FLAG_PLAY_MASK = 8'h06;
  localparam int unsigned FLAG_LOOP_BIT = 0;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2
  } pcmp_func_e;

  // command from the front end to one voice lane
  typedef struct packed {
    logic                 load;
    logic                 wr;
    logic                 tick;
    logic [REG_SEL_W-1:0] sel;
    logic [7:0]           wdata;
  } pcmp_cmd_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;
    logic [FETCH_W-1:0]       fetch_addr;
    logic [7:0]               flags;
  } pcmp_lane_out_t;

endpackage

// ===== sv/pcmp_regmem.sv =====
// ----------------------------------------------------------------------------
// pcmp_regmem
// 256 byte register file image for bus reads, one write and one registered
// read port, per entry valid bits give the all-zero reset
// ----------------------------------------------------------------------------
module pcmp_regmem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [pcmp_pkg::REG_ADDR_W-1:0]  waddr_i,
  input  logic [7:0]                       wdata_i,
  input  logic                             re_i,
  input  logic [pcmp_pkg::REG_ADDR_W-1:0]  raddr_i,
  output logic [7:0]                       rdata_o
);
  import pcmp_pkg::*;

  logic [7:0]           mem [REG_BYTES];
  logic [REG_BYTES-1:0] valid_q;
  logic [7:0]           rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // never written entries read as zero
  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

// ===== sv/pcmp_lane.sv =====
// ----------------------------------------------------------------------------
// pcmp_lane
// one voice: register shadow, 26.16 position stepping with loop and end
// handling, and the registered volume products for the mix
// ----------------------------------------------------------------------------
`include "eight_voice_pcm_sample_player_core_assert.svh"

module pcmp_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pcmp_pkg::pcmp_cmd_t      cmd_i,
  input  logic [7:0]               sample_i,
  output pcmp_pkg::pcmp_lane_out_t lane_o
);
  import pcmp_pkg::*;

  logic [PTR_W-1:0]  start_q, start_d;
  logic [PTR_W-1:0]  lstart_q, lstart_d;
  logic [PTR_W-1:0]  lend_q, lend_d;
  logic [PTR_W-1:0]  end_q, end_d;
  logic [FRAC_W-1:0] step_q, step_d;
  logic [7:0]        vol_l_q, vol_l_d;
  logic [7:0]        vol_r_q, vol_r_d;
  logic [7:0]        flags_q, flags_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic              looped_q, looped_d;
  logic signed [PROD_W-1:0] prod_l_q, prod_l_d;
  logic signed [PROD_W-1:0] prod_r_q, prod_r_d;

  logic               active;
  logic               restart;
  logic [FRAC_W:0]    frac_sum;
  logic [POS_W:0]     pos_adv;
  logic [POS_W+1:0]   cur_addr;
  logic               reach_lend;
  logic               reach_end;
  logic [PTR_W:0]     loop_pos;
  logic [POS_W-1:0]   loop_pos_w;

  assign active   = (flags_q & FLAG_PLAY_MASK) != 8'h00;
  assign restart  = cmd_i.wr && (cmd_i.sel == REG_FLAGS) &&
                    (cmd_i.wdata != flags_q) && (cmd_i.wdata != 8'h00);

  assign frac_sum = {1'b0, frac_q} + {1'b0, step_q};
  assign pos_adv  = {pos_q[POS_W-1], pos_q} + {{POS_W{1'b0}}, frac_sum[FRAC_W]};
  assign cur_addr = {pos_adv[POS_W], pos_adv} + {{(POS_W+2-PTR_W){1'b0}}, start_q};
  assign reach_lend = $signed(cur_addr) >= $signed({{(POS_W+2-PTR_W){1'b0}}, lend_q});
  assign reach_end  = $signed(cur_addr) >= $signed({{(POS_W+2-PTR_W){1'b0}}, end_q});
  assign loop_pos   = {1'b0, lstart_q} - {1'b0, start_q};
  assign loop_pos_w = {loop_pos[PTR_W], loop_pos};

  // register writes
  always_comb begin
    start_d  = start_q;
    lstart_d = lstart_q;
    lend_d   = lend_q;
    end_d    = end_q;
    step_d   = step_q;
    vol_l_d  = vol_l_q;
    vol_r_d  = vol_r_q;
    flags_d  = flags_q;
    pos_d    = pos_q;
    frac_d   = frac_q;
    looped_d = looped_q;
    if (cmd_i.wr) begin
      unique case (cmd_i.sel)
        REG_START_LO:   start_d[7:0]    = cmd_i.wdata;
        REG_START_MID:  start_d[15:8]   = cmd_i.wdata;
        REG_START_HI:   start_d[23:16]  = cmd_i.wdata;
        REG_LSTART_LO:  lstart_d[7:0]   = cmd_i.wdata;
        REG_LSTART_MID: lstart_d[15:8]  = cmd_i.wdata;
        REG_LSTART_HI:  lstart_d[23:16] = cmd_i.wdata;
        REG_LEND_LO:    lend_d[7:0]     = cmd_i.wdata;
        REG_LEND_MID:   lend_d[15:8]    = cmd_i.wdata;
        REG_LEND_HI:    lend_d[23:16]   = cmd_i.wdata;
        REG_END_LO:     end_d[7:0]      = cmd_i.wdata;
        REG_END_MID:    end_d[15:8]     = cmd_i.wdata;
        REG_END_HI:     end_d[23:16]    = cmd_i.wdata;
        REG_STEP_LO:    step_d[7:0]     = cmd_i.wdata;
        REG_STEP_HI:    step_d[15:8]    = cmd_i.wdata;
        REG_VOL_L:      vol_l_d         = cmd_i.wdata;
        REG_VOL_R:      vol_r_d         = cmd_i.wdata;
        REG_FLAGS:      flags_d         = cmd_i.wdata;
        default:        ;
      endcase
      if (restart) begin
        pos_d    = '0;
        frac_d   = '0;
        looped_d = 1'b0;
      end
    end else if (cmd_i.tick && active) begin
      pos_d  = pos_adv[POS_W-1:0];
      frac_d = frac_sum[FRAC_W-1:0];
      if (looped_q) begin
        if (reach_lend) begin
          pos_d = loop_pos_w;
        end
      end else if (reach_end) begin
        if (flags_q[FLAG_LOOP_BIT]) begin
          pos_d    = loop_pos_w;
          looped_d = 1'b1;
        end else begin
          flags_d = 8'h00;
          pos_d   = '0;
          frac_d  = '0;
        end
      end
    end
  end

  // products taken with the pre-step volumes
  always_comb begin
    prod_l_d = prod_l_q;
    prod_r_d = prod_r_q;
    if (cmd_i.load) begin
      if (cmd_i.tick && active) begin
        prod_l_d = PROD_W'($signed(sample_i)) * PROD_W'($signed(vol_l_q));
        prod_r_d = PROD_W'($signed(sample_i)) * PROD_W'($signed(vol_r_q));
      end else begin
        prod_l_d = '0;
        prod_r_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      lstart_q <= '0;
      lend_q   <= '0;
      end_q    <= '0;
      step_q   <= '0;
      vol_l_q  <= '0;
      vol_r_q  <= '0;
      flags_q  <= '0;
      pos_q    <= '0;
      frac_q   <= '0;
      looped_q <= 1'b0;
      prod_l_q <= '0;
      prod_r_q <= '0;
    end else begin
      start_q  <= start_d;
      lstart_q <= lstart_d;
      lend_q   <= lend_d;
      end_q    <= end_d;
      step_q   <= step_d;
      vol_l_q  <= vol_l_d;
      vol_r_q  <= vol_r_d;
      flags_q  <= flags_d;
      pos_q    <= pos_d;
      frac_q   <= frac_d;
      looped_q <= looped_d;
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
  end

  assign lane_o.prod_l     = prod_l_q;
  assign lane_o.prod_r     = prod_r_q;
  assign lane_o.fetch_addr = start_q[FETCH_W-1:0] + pos_q[FETCH_W-1:0];
  assign lane_o.flags      = flags_q;

  `PCMP_ASSERT_NEXT(a_restart_clears, restart,
    pos_q == '0 && frac_q == '0 && !looped_q, "voice restart did not clear its position")
  `PCMP_ASSERT_SAME(a_loop_on_tick, $rose(looped_q),
    $past(cmd_i.tick) && $past(active), "loop mark set outside a tick")
  `PCMP_ASSERT_NEXT(a_prod_hold, !cmd_i.load,
    $stable(prod_l_q) && $stable(prod_r_q), "products changed without an item")

endmodule

// ===== sv/pcmp_mix.sv =====
// ----------------------------------------------------------------------------
// pcmp_mix
// merge stage: sums the lane products per side and scales by 1/16
// ----------------------------------------------------------------------------
module pcmp_mix (
  input  pcmp_pkg::pcmp_lane_out_t                lanes_i [pcmp_pkg::MAX_VOICES],
  output logic signed [pcmp_pkg::OUT_W-1:0]       left_o,
  output logic signed [pcmp_pkg::OUT_W-1:0]       right_o
);
  import pcmp_pkg::*;

  logic signed [MIX_W-1:0] sum_l;
  logic signed [MIX_W-1:0] sum_r;

  always_comb begin
    sum_l = '0;
    sum_r = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      sum_l = sum_l + MIX_W'(lanes_i[i].prod_l);
      sum_r = sum_r + MIX_W'(lanes_i[i].prod_r);
    end
  end

  // arithmetic shift by four, floor rounding
  assign left_o  = sum_l[MIX_W-1 -: OUT_W];
  assign right_o = sum_r[MIX_W-1 -: OUT_W];

endmodule

// ===== sv/eight_voice_pcm_sample_player_core.sv =====
// ----------------------------------------------------------------------------
// eight_voice_pcm_sample_player_core
// eight voice pcm player with a 256 byte register file, one lane per voice
//
//   channel  dir  tdata                                          tuser
//   s_axis   in   reg_addr, reg_data, sample_byte_0..7 (80b)     func (2b)
//   m_axis   out  read_data, left_out, right_out,                -
//                 fetch_addr_0..7, 2 zero pad bits (208b)
//
// one item per cycle while the output is accepted; a result passes the lane stage
// with registered products and register file read, then the output register fed
// by the mix adder tree and the fetch address adders
// no clearing pass after reset: register file entries carry valid bits
// a held output register stalls the lane stage, which then stops input
// ----------------------------------------------------------------------------
`include "eight_voice_pcm_sample_player_core_assert.svh"

module eight_voice_pcm_sample_player_core #(
  parameter int unsigned VOICES = pcmp_pkg::NUM_VOICES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // reg_addr [7:0], reg_data [15:8], sample_byte_0..7 [23:16] .. [79:72]
  input  logic [pcmp_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // func [1:0]
  input  logic [pcmp_pkg::S_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // read_data [7:0], left_out [22:8], right_out [37:23],
  // fetch_addr_0..7 [58:38] .. [205:185], zero [207:206]
  output logic [pcmp_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);
  import pcmp_pkg::*;

  localparam int unsigned OUT_PAD = M_TDATA_W - 8 - 2 * OUT_W - MAX_VOICES * FETCH_W;

  pcmp_func_e            in_func;
  logic [REG_ADDR_W-1:0] in_addr;
  logic [7:0]            in_data;
  logic [VOICE_W-1:0]    in_voice;
  logic                  in_voice_ok;
  logic                  accept;
  logic                  s1_move;

  logic                  s1_v_q, s1_v_d;
  logic                  s1_read_q, s1_read_d;
  logic                  s1_shadow_q, s1_shadow_d;
  logic [7:0]            s1_flags_q, s1_flags_d;

  logic                  out_v_q, out_v_d;
  logic [7:0]            out_rd_q, out_rd_d;
  logic signed [OUT_W-1:0] out_left_q, out_left_d;
  logic signed [OUT_W-1:0] out_right_q, out_right_d;
  logic [FETCH_W-1:0]    out_fetch_q [MAX_VOICES];
  logic [FETCH_W-1:0]    out_fetch_d [MAX_VOICES];

  pcmp_lane_out_t        lanes [MAX_VOICES];
  logic [7:0]            mem_rdata;
  logic signed [OUT_W-1:0] mix_left;
  logic signed [OUT_W-1:0] mix_right;

  assign in_func     = pcmp_func_e'(s_axis_tuser_i);
  assign in_addr     = s_axis_tdata_i[7:0];
  assign in_data     = s_axis_tdata_i[15:8];
  assign in_voice    = in_addr[REG_ADDR_W-1 -: VOICE_W];
  assign in_voice_ok = 32'(in_voice) < VOICES;

  assign s1_move         = s1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_v_q || s1_move;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar i = 0; i < MAX_VOICES; i++) begin : g_lane
    if (i < VOICES) begin : g_on
      pcmp_cmd_t cmd;
      assign cmd.load  = accept;
      assign cmd.wr    = accept && (in_func == FUNC_WRITE) &&
                         (in_voice == VOICE_W'(i));
      assign cmd.tick  = accept && (in_func == FUNC_TICK);
      assign cmd.sel   = in_addr[REG_SEL_W-1:0];
      assign cmd.wdata = in_data;

      pcmp_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd),
        .sample_i (s_axis_tdata_i[16 + 8 * i +: 8]),
        .lane_o   (lanes[i])
      );
    end else begin : g_off
      assign lanes[i] = '0;
    end
  end

  pcmp_regmem u_regmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && (in_func == FUNC_WRITE)),
    .waddr_i (in_addr),
    .wdata_i (in_data),
    .re_i    (accept && (in_func == FUNC_READ)),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata)
  );

  pcmp_mix u_mix (
    .lanes_i (lanes),
    .left_o  (mix_left),
    .right_o (mix_right)
  );

  // flag bytes of live voices are cleared by ticks, so they read from the lane
  always_comb begin
    s1_v_d      = s1_v_q;
    s1_read_d   = s1_read_q;
    s1_shadow_d = s1_shadow_q;
    s1_flags_d  = s1_flags_q;
    if (accept) begin
      s1_v_d      = 1'b1;
      s1_read_d   = in_func == FUNC_READ;
      s1_shadow_d = in_voice_ok && (in_addr[REG_SEL_W-1:0] == REG_FLAGS);
      s1_flags_d  = lanes[in_voice].flags;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end
  end

  // fetch addresses are sampled here, after this item's update and before the next
  always_comb begin
    out_v_d     = out_v_q;
    out_rd_d    = out_rd_q;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    out_fetch_d = out_fetch_q;
    if (s1_move) begin
      out_v_d     = 1'b1;
      out_rd_d    = !s1_read_q ? 8'h00 : (s1_shadow_q ? s1_flags_q : mem_rdata);
      out_left_d  = mix_left;
      out_right_d = mix_right;
      for (int i = 0; i < MAX_VOICES; i++) begin
        out_fetch_d[i] = lanes[i].fetch_addr;
      end
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_read_q   <= s1_read_d;
    s1_shadow_q <= s1_shadow_d;
    s1_flags_q  <= s1_flags_d;
    out_rd_q    <= out_rd_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
    out_fetch_q <= out_fetch_d;
  end

  assign m_axis_tvalid_o = out_v_q;

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[7:0]   = out_rd_q;
    m_axis_tdata_o[22:8]  = out_left_q;
    m_axis_tdata_o[37:23] = out_right_q;
    for (int i = 0; i < MAX_VOICES; i++) begin
      m_axis_tdata_o[38 + FETCH_W * i +: FETCH_W] = out_fetch_q[i];
    end
    m_axis_tdata_o[M_TDATA_W-1 -: OUT_PAD] = '0;
  end

  `PCMP_ASSERT_NEXT(a_s1_hold, s1_v_q && !s1_move, s1_v_q, "lane stage dropped an item")
  `PCMP_ASSERT_NEXT(a_read_tracked, accept && in_func == FUNC_READ,
    s1_v_q && s1_read_q, "read item lost its read marker")
  `PCMP_ASSERT_SAME(a_read_no_mix, out_v_q && out_rd_q != 8'h00,
    out_left_q == '0 && out_right_q == '0, "read result carries mix data")
  `PCMP_ASSERT_NEXT(a_out_load, s1_move, out_v_q, "output register missed a result")

endmodule
